[rtl/cbfp_pkg.sv]
// Shared types and constants for the carbon-ranked best-fit placer.
// No dependencies; used by every module of the block by scoped name.
package cbfp_pkg;

  localparam int MAX_HOSTS_DEF = 64;

  localparam int OP_W      = 2;
  localparam int CARBON_W  = 24;
  localparam int SITE_W    = 4;
  localparam int IDENT_W   = 16;
  localparam int CPU_W     = 32;
  localparam int RAM_W     = 20;
  localparam int VM_W      = 16;

  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_PLACE = 2'd2;

  // One row of the host table.
  typedef struct packed {
    logic [RAM_W-1:0]    ram;
    logic [CPU_W-1:0]    cpu;
    logic                enabled;
    logic [IDENT_W-1:0]  ident;
    logic [SITE_W-1:0]   site;
    logic [CARBON_W-1:0] carbon;
  } host_entry_t;

  // Demand of the virtual machine being placed.
  typedef struct packed {
    logic [CPU_W-1:0] cpu;
    logic [RAM_W-1:0] ram;
  } demand_t;

endpackage

[rtl/cbfp_table.sv]
// Host table memory: one write port, one read port with registered data.
// Depends on cbfp_pkg for the row type.
module cbfp_table #(
  parameter int MAX_HOSTS = cbfp_pkg::MAX_HOSTS_DEF,
  parameter int IW        = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IW-1:0]        waddr,
  input  cbfp_pkg::host_entry_t wdata,
  input  logic                 re,
  input  logic [IW-1:0]        raddr,
  output cbfp_pkg::host_entry_t rdata
);

  cbfp_pkg::host_entry_t mem [MAX_HOSTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/cbfp_rank.sv]
// Shared fit test and key comparator; holds the best host seen in a scan.
// Depends on cbfp_pkg for the row and demand types.
module cbfp_rank #(
  parameter int IW = $clog2(cbfp_pkg::MAX_HOSTS_DEF)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  upd_valid,
  input  cbfp_pkg::host_entry_t upd_entry,
  input  logic [IW-1:0]         upd_idx,
  input  cbfp_pkg::demand_t     need,
  output logic                  found,
  output cbfp_pkg::host_entry_t best,
  output logic [IW-1:0]         best_idx
);

  localparam int KEY_W = cbfp_pkg::CARBON_W + cbfp_pkg::SITE_W + cbfp_pkg::CPU_W;

  logic             fits;
  logic             less;
  logic [KEY_W-1:0] cand_key;
  logic [KEY_W-1:0] best_key;

  // Slack ordering equals residual CPU ordering, since the demand is common.
  assign cand_key = {upd_entry.carbon, upd_entry.site, upd_entry.cpu};
  assign best_key = {best.carbon, best.site, best.cpu};
  assign fits = upd_entry.enabled && (upd_entry.cpu >= need.cpu)
                && (upd_entry.ram >= need.ram);
  assign less = !found || (cand_key < best_key);

  always_ff @(posedge clk) begin
    if (rst || start) begin
      found <= 1'b0;
    end else if (upd_valid && fits && less) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_valid && fits && less) begin
      best     <= upd_entry;
      best_idx <= upd_idx;
    end
  end

endmodule

[rtl/carbon_ranked_best_fit_placer.sv]
// Carbon-ranked best-fit placer: input stream of clear/load/place items,
// output stream of placement results. Uses cbfp_pkg, cbfp_table, cbfp_rank.
//
// Input channel (s_*): s_tuser carries the op (clear, load, place), s_tdata
// the host and virtual machine fields. Clear and load items give no
// result; a load into a full table is dropped. Op code 3 is ignored.
// Output channel (m_*): one beat per place item with the vm id, the chosen
// host id (zero if none) and the placed flag in m_tuser.
// A place item reads every loaded host from the table through one read
// port, one row a cycle, and ranks it in a single shared comparator; then
// a charge step charges the winner. The next item is taken once the
// result is in the output register.
// s_tready is low while a placement is in progress.
// If the receiver stalls, the result holds in the output register; clear
// and load items are still taken, and a following place item scans but
// waits in its charge step until the register is free.
// Reset (rst, synchronous) empties the table and drops any pending result.
module carbon_ranked_best_fit_placer #(
  parameter int MAX_HOSTS = cbfp_pkg::MAX_HOSTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // site_carbon, site_index, host_ident, host_active, host_cpu_free,
  // host_ram_free, vm_ident, vm_cpu_need, vm_ram_need, zero pad
  input  logic [cbfp_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [cbfp_pkg::OP_W-1:0]       s_tuser,   // op
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [cbfp_pkg::OUT_DATA_W-1:0] m_tdata,   // placed_vm, chosen_host
  output logic                            m_tuser    // placed
);

  localparam int IW = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;
  localparam int CW = $clog2(MAX_HOSTS + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_CHARGE = 2'd2;

  logic [1:0]              state;
  logic [CW-1:0]           count;
  logic [CW-1:0]           cnt;
  logic [CW-1:0]           cnt_next;
  logic                    rd_pend;
  logic                    rd_last;
  logic [IW-1:0]           rd_idx;
  logic [cbfp_pkg::VM_W-1:0] vm_id;
  cbfp_pkg::demand_t       need;

  cbfp_pkg::host_entry_t   in_entry;
  cbfp_pkg::demand_t       in_need;
  logic [cbfp_pkg::VM_W-1:0] in_vm;

  logic                    accept;
  logic                    out_free;
  logic                    issue;
  logic                    start;
  logic                    tbl_we;
  logic [IW-1:0]           tbl_waddr;
  cbfp_pkg::host_entry_t   tbl_wdata;
  cbfp_pkg::host_entry_t   rd_entry;
  cbfp_pkg::host_entry_t   charged;
  logic                    found;
  cbfp_pkg::host_entry_t   best;
  logic [IW-1:0]           best_idx;

  assign in_entry.carbon  = s_tdata[23:0];
  assign in_entry.site    = s_tdata[27:24];
  assign in_entry.ident   = s_tdata[43:28];
  assign in_entry.enabled = s_tdata[44];
  assign in_entry.cpu     = s_tdata[76:45];
  assign in_entry.ram     = s_tdata[96:77];
  assign in_vm            = s_tdata[112:97];
  assign in_need.cpu      = s_tdata[144:113];
  assign in_need.ram      = s_tdata[164:145];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign start    = accept && (s_tuser == cbfp_pkg::OP_PLACE);
  assign issue    = (state == ST_SCAN) && (cnt != count);
  assign cnt_next = cnt + CW'(1);

  always_comb begin
    charged     = best;
    charged.cpu = best.cpu - need.cpu;
    charged.ram = best.ram - need.ram;
  end

  // Write port: loads in idle, the winner's charge at the end of a place.
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = count[IW-1:0];
    tbl_wdata = in_entry;
    if (state == ST_CHARGE) begin
      tbl_we    = out_free && found;
      tbl_waddr = best_idx;
      tbl_wdata = charged;
    end else if (accept && (s_tuser == cbfp_pkg::OP_LOAD)
                 && (count < CW'(MAX_HOSTS))) begin
      tbl_we = 1'b1;
    end
  end

  cbfp_table #(.MAX_HOSTS(MAX_HOSTS), .IW(IW)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (issue),
    .raddr (cnt[IW-1:0]),
    .rdata (rd_entry)
  );

  cbfp_rank #(.IW(IW)) u_rank (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .upd_valid (rd_pend),
    .upd_entry (rd_entry),
    .upd_idx   (rd_idx),
    .need      (need),
    .found     (found),
    .best      (best),
    .best_idx  (best_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      cnt     <= '0;
      rd_pend <= 1'b0;
      rd_last <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (issue) begin
        rd_last <= (cnt_next == count);
        cnt     <= cnt_next;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser == cbfp_pkg::OP_CLEAR) begin
              count <= '0;
            end else if (tbl_we) begin
              count <= count + CW'(1);
            end else if (start) begin
              cnt   <= '0;
              state <= (count == '0) ? ST_CHARGE : ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // the last row is being ranked this cycle
          if (rd_pend && rd_last) begin
            state <= ST_CHARGE;
          end
        end
        ST_CHARGE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx <= cnt[IW-1:0];
    end
    if (start) begin
      need  <= in_need;
      vm_id <= in_vm;
    end
  end

  // Output register: load in the charge step, hold until the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_CHARGE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_CHARGE) && out_free) begin
      m_tdata <= {(found ? best.ident : cbfp_pkg::IDENT_W'(0)), vm_id};
      m_tuser <= found;
    end
  end

endmodule

[rtl/cbfp_checker.sv]
// Port-level checks for the carbon-ranked best-fit placer, bound to the top.
// Depends on cbfp_pkg for the op codes and port widths.
module cbfp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [cbfp_pkg::OP_W-1:0]       s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [cbfp_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tuser
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // A place beat closes the input until its result is built.
  a_place_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == cbfp_pkg::OP_PLACE) |=> !s_tready)
    else $error("input taken during a placement");

  // A result that was not placed names no host.
  a_unplaced_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[31:16] == 16'd0))
    else $error("unplaced result carries a host id");

  // Clear, load and unused ops never raise a result.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser != cbfp_pkg::OP_PLACE) && !m_tvalid |=> !m_tvalid)
    else $error("result raised by a non-place beat");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind carbon_ranked_best_fit_placer cbfp_checker u_cbfp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
